// ----- rtl/cfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants of the CRC-16 frame builder
// Holds the queue entry, the byte sequencer phases and the CRC-16/MODBUS fold.
// ----------------------------------------------------------------------------
package cfb_pkg;

    localparam logic [7:0]  HDR_BYTE    = 8'hFE;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam int          QUEUE_DEPTH = 4;

    // One classified input word, as held in the queue
    typedef struct packed {
        logic       has_hdr;
        logic       has_data;
        logic       has_crc;
        logic [7:0] len;
        logic [7:0] cmd;
        logic [7:0] data;
    } cfb_entry_t;

    // Byte positions within one entry
    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_LEN,
        PH_CMD,
        PH_DATA,
        PH_CRCL,
        PH_CRCH
    } cfb_phase_t;

    // Fold one byte into a reflected CRC-16 (eight shift steps)
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/cfb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_front: input classifier
// Decodes the marks of an input word and saturates the frame length.
// ----------------------------------------------------------------------------
module cfb_front #(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic [7:0]        payload_byte,
    input  wire logic [7:0]        frame_command,
    input  wire logic [6:0]        payload_count,
    input  wire logic              first_byte,
    input  wire logic              last_byte,
    input  wire logic              empty_frame,
    output cfb_pkg::cfb_entry_t    entry
);

    localparam int unsigned LIMIT = BUFFER_BYTES - 6;

    logic [7:0] len_sat;

    // Clamp the count so the frame fits the buffer, then add header overhead
    always_comb
    begin
        if (32'(payload_count) > LIMIT)
            len_sat = 8'(LIMIT + 3);
        else
            len_sat = {1'b0, payload_count} + 8'd3;
    end

    // Classify: an empty frame overrides the other marks
    always_comb
    begin
        entry.cmd  = frame_command;
        entry.data = payload_byte;
        if (empty_frame)
        begin
            entry.has_hdr  = 1'b1;
            entry.has_data = 1'b0;
            entry.has_crc  = 1'b1;
            entry.len      = 8'd3;
        end
        else
        begin
            entry.has_hdr  = first_byte;
            entry.has_data = 1'b1;
            entry.has_crc  = last_byte;
            entry.len      = len_sat;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cfb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_queue: short entry queue
// Decouples the classifier from the byte sequencer so each side stalls alone.
// ----------------------------------------------------------------------------
module cfb_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  cfb_pkg::cfb_entry_t      push_entry,
    output logic                     full,
    input  wire logic                pop,
    output logic                     head_valid,
    output cfb_pkg::cfb_entry_t      head_entry
);

    localparam int PTR_W = $clog2(cfb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cfb_pkg::QUEUE_DEPTH + 1);

    cfb_pkg::cfb_entry_t mem [cfb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(cfb_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

// ----- rtl/cfb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_back: byte sequencer
// Walks each queued entry byte by byte, folds the CRC, drives the output word.
// ----------------------------------------------------------------------------
module cfb_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  cfb_pkg::cfb_entry_t      head_entry,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               out_byte,
    output logic                     out_last
);

    cfb_pkg::cfb_phase_t phase_reg, phase_next, cur_phase, start_phase, after_phase;
    logic        started_reg, started_next;
    logic [15:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        advance, entry_done;
    logic [7:0]  cur_byte;
    logic [15:0] crc_base;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign advance   = head_valid && (!valid_reg || out_ready);

    // Pick the first byte position of a fresh entry
    always_comb
    begin
        if (head_entry.has_hdr)
            start_phase = cfb_pkg::PH_HDR0;
        else if (head_entry.has_data)
            start_phase = cfb_pkg::PH_DATA;
        else
            start_phase = cfb_pkg::PH_CRCL;
        cur_phase = started_reg ? phase_reg : start_phase;
    end

    // Select the byte, the next position and the CRC update
    always_comb
    begin
        entry_done  = 1'b0;
        after_phase = cur_phase;
        cur_byte    = head_entry.data;
        crc_base    = (cur_phase == cfb_pkg::PH_HDR0) ? cfb_pkg::CRC_INIT : crc_reg;
        unique case (cur_phase)
            cfb_pkg::PH_HDR0:
            begin
                cur_byte    = cfb_pkg::HDR_BYTE;
                after_phase = cfb_pkg::PH_HDR1;
            end
            cfb_pkg::PH_HDR1:
            begin
                cur_byte    = cfb_pkg::HDR_BYTE;
                after_phase = cfb_pkg::PH_LEN;
            end
            cfb_pkg::PH_LEN:
            begin
                cur_byte    = head_entry.len;
                after_phase = cfb_pkg::PH_CMD;
            end
            cfb_pkg::PH_CMD:
            begin
                cur_byte    = head_entry.cmd;
                after_phase = head_entry.has_data ? cfb_pkg::PH_DATA : cfb_pkg::PH_CRCL;
            end
            cfb_pkg::PH_DATA:
            begin
                cur_byte    = head_entry.data;
                after_phase = cfb_pkg::PH_CRCL;
                entry_done  = !head_entry.has_crc;
            end
            cfb_pkg::PH_CRCL:
            begin
                cur_byte    = crc_reg[7:0];
                after_phase = cfb_pkg::PH_CRCH;
            end
            cfb_pkg::PH_CRCH:
            begin
                cur_byte    = crc_reg[15:8];
                after_phase = cfb_pkg::PH_HDR0;
                entry_done  = 1'b1;
            end
            default:
            begin
                cur_byte    = head_entry.data;
                after_phase = cfb_pkg::PH_HDR0;
            end
        endcase
    end

    // Sequence state and output register
    always_comb
    begin
        pop          = 1'b0;
        phase_next   = phase_reg;
        started_next = started_reg;
        crc_next     = crc_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (advance)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            last_next  = (cur_phase == cfb_pkg::PH_CRCH);
            if (cur_phase == cfb_pkg::PH_CRCH)
                crc_next = cfb_pkg::CRC_INIT;
            else if (cur_phase != cfb_pkg::PH_CRCL)
                crc_next = cfb_pkg::crc_fold(crc_base, cur_byte);
            if (entry_done)
            begin
                pop          = 1'b1;
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                phase_next   = after_phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= cfb_pkg::PH_HDR0;
            started_reg <= 1'b0;
            crc_reg     <= cfb_pkg::CRC_INIT;
            valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            started_reg <= started_next;
            crc_reg     <= crc_next;
            valid_reg   <= valid_next;
        end
    end

    // Hold the output word payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule
`default_nettype wire

// ----- rtl/crc16_frame_builder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_builder: serial frame builder with CRC-16/MODBUS trailer
// Classifier, entry queue and byte sequencer with a registered output word.
// ----------------------------------------------------------------------------
// One input word is taken per cycle while the four-entry queue has room. The
// byte sequencer sends one output word per cycle while entries are queued and
// the output is not stalled, so a plain payload word yields one byte, a first
// word five, a last word three, a first-and-last word seven and an empty frame
// six; the sustained input rate is set by the sequencer's byte output. Frames
// are 0xFE 0xFE, length (count plus 3, count clamped to BUFFER_BYTES - 6),
// command, payload, then CRC low and high; m_tlast marks the CRC high byte.
module crc16_frame_builder #(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // payload_byte, frame_command, payload_count, pad
    input  wire logic [1:0]  s_tuser,   // first_byte, empty_frame
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic             m_tlast    // frame_end
);

    cfb_pkg::cfb_entry_t in_entry, head_entry;
    logic                q_full, head_valid, pop;

    assign s_tready = !q_full;

    // Classify the incoming word
    cfb_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .payload_byte  (s_tdata[7:0]),
        .frame_command (s_tdata[15:8]),
        .payload_count (s_tdata[22:16]),
        .first_byte    (s_tuser[0]),
        .last_byte     (s_tlast),
        .empty_frame   (s_tuser[1]),
        .entry         (in_entry)
    );

    // Buffer classified words
    cfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_entry (in_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Emit frame bytes
    cfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
`default_nettype wire

// ----- rtl/cfb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfb_checker: port-level checks of the frame builder
// Watches the output stream for reset, hold and trailer behavior.
// ----------------------------------------------------------------------------
module cfb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // Output is quiet while reset is applied
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output word valid during reset");

    // Hold a stalled word
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("output word changed while stalled");

    // CRC high byte always follows a CRC low byte, so frame ends never abut
    a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !(m_tvalid && m_tready && m_tlast))
        else $error("two frame-end words in a row");

endmodule

bind crc16_frame_builder cfb_checker u_cfb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
